// ===== rtl/quaternion_thrust_velocity_update_unit_assert.svh =====
// Assertion macros for the thrust velocity update unit.
// Needs a clock named clk and a synchronous reset named rst in the including module.
`ifndef QUATERNION_THRUST_VELOCITY_UPDATE_UNIT_ASSERT_SVH
`define QUATERNION_THRUST_VELOCITY_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QTVU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qtvu: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define QTVU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qtvu: next-cycle check failed");

`endif

// ===== rtl/qtvu_pkg.sv =====
// Shared types and constants of the thrust velocity update unit.
// No dependencies.
package qtvu_pkg;

  localparam int REG_MAX_THRUST = 0;
  localparam int REG_STEP_TIME  = 1;

  localparam logic [31:0] MAX_THRUST_RESET = 32'd0;
  localparam logic [23:0] STEP_TIME_RESET  = 24'd279620;

  // Throttle full scale in Q16.16 and direction full scale in Q1.30.
  localparam logic [16:0] THR_ONE = 17'd65536;
  localparam logic [30:0] DIR_ONE = 31'h4000_0000;

  // Restoring division: quotient bits, bits resolved per stage, stage count.
  localparam int DIV_STEPS     = 31;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  typedef logic [32:0] norm_t;   // w^2+x^2+y^2+z^2, at most 2^32
  typedef logic [33:0] rem_t;    // division remainder, doubled
  typedef logic [30:0] dir_t;    // direction magnitude, Q1.30
  typedef logic [47:0] speed_t;  // speed change, Q.16

endpackage

// ===== rtl/quaternion_thrust_velocity_update_unit.sv =====
// Thrust velocity update unit: top level, whole datapath in one pipeline.
// Depends on qtvu_pkg and quaternion_thrust_velocity_update_unit_assert.svh.
//
// Usage
//   One ship per input word: orientation quaternion, throttle, inverse mass
//   and velocity. One output word per input: the velocity after one time step
//   of thrust along the rotated forward axis, saturated, plus a flag raised
//   when the quaternion was zero and (1,0,0) stood in for the direction.
//   Both channels are valid/ready; a word moves when valid and ready are high.
//   max_thrust (address 0) and step_time (address 4) sit on the APB port;
//   write them only while no word is in flight.
// Timing
//   25 register stages from input to output: 6 front stages (quaternion
//   products, thrust, acceleration and speed products), 16 divider stages
//   resolving two quotient bits each (one in the last) for the normalisation,
//   3 back stages (scaling, magnitude, saturating add). One word is accepted
//   every cycle while the receiver keeps up.
// Stalls
//   When the receiver holds ready low, the last result drops into a one-word
//   skid register and the pipeline freezes; in_ready falls with it and rises
//   again once the skid word is taken. Nothing is lost or repeated.
// Reset
//   rst clears all valid bits and the skid; max_thrust resets to 0, step_time to 279620.
module quaternion_thrust_velocity_update_unit
  import qtvu_pkg::*;
#(
  parameter int QUAT_WIDTH = 16,
  parameter int VEL_WIDTH  = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [QUAT_WIDTH-1:0] quat_w,
  input  logic signed [QUAT_WIDTH-1:0] quat_x,
  input  logic signed [QUAT_WIDTH-1:0] quat_y,
  input  logic signed [QUAT_WIDTH-1:0] quat_z,
  input  logic signed [31:0]          throttle_level,
  input  logic [31:0]                 inverse_mass,
  input  logic signed [VEL_WIDTH-1:0] vel_x,
  input  logic signed [VEL_WIDTH-1:0] vel_y,
  input  logic signed [VEL_WIDTH-1:0] vel_z,
  // output words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VEL_WIDTH-1:0] new_vel_x,
  output logic signed [VEL_WIDTH-1:0] new_vel_y,
  output logic signed [VEL_WIDTH-1:0] new_vel_z,
  output logic                        default_direction
);

`include "quaternion_thrust_velocity_update_unit_assert.svh"

  localparam int NS   = DIV_STAGES + 9;   // total pipeline stages
  localparam int DF   = 5;                // stage that loads the divider
  localparam int DL   = DF + DIV_STAGES;  // last divider stage
  localparam int QSH  = (QUAT_WIDTH > 16) ? QUAT_WIDTH - 16 : 0;
  localparam int QTW  = ((QUAT_WIDTH > 16) ? QUAT_WIDTH : 16) + 1;
  localparam int SW   = ((VEL_WIDTH > 50) ? VEL_WIDTH : 50) + 1;
  localparam logic signed [SW-1:0] VMAX =
    {{(SW-VEL_WIDTH+1){1'b0}}, {(VEL_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN = ~VMAX;

  // ---------------------------------------------------------------------------
  // Configuration registers. Index is paddr[2]; the low address bits are
  // ignored, so every address lands on one of the two registers.
  // ---------------------------------------------------------------------------
  logic [31:0] max_thrust;
  logic [23:0] step_time;
  logic        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_thrust <= MAX_THRUST_RESET;
      step_time  <= STEP_TIME_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_sel)
        1'(REG_MAX_THRUST): max_thrust <= pwdata;
        1'(REG_STEP_TIME):  step_time  <= pwdata[23:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      1'(REG_MAX_THRUST): prdata = max_thrust;
      1'(REG_STEP_TIME):  prdata = {8'd0, step_time};
      default:            prdata = 32'd0;
    endcase
  end

  // Wide quaternion components: divide by 2^QSH, truncating toward zero.
  function automatic logic signed [15:0] reduce_quat(input logic signed [QUAT_WIDTH-1:0] r);
    logic signed [QTW-1:0] t;
    logic signed [QTW-1:0] s;
    t = QTW'(r);
    if (r[QUAT_WIDTH-1]) t = t + QTW'((1 << QSH) - 1);
    s = t >>> QSH;
    return s[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline advances together unless the skid word
  // is waiting. The skid catches the last stage whenever the receiver stalls.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] vld;
  logic          adv;
  logic          skid_vld;
  logic signed [VEL_WIDTH-1:0] skid_vel [3];
  logic                        skid_dflt;

  assign adv      = !skid_vld;
  assign in_ready = adv;

  // Pipeline payload
  logic signed [15:0] q0 [4];
  logic [16:0]        thr0;
  logic [31:0]        im_p [0:1];
  logic signed [31:0] ww1, xx1, yy1, zz1, xy1, wz1, xz1, wy1;
  logic [47:0]        thrust1;
  logic [63:0]        pa2;
  logic [47:0]        pb2;
  logic [47:0]        accel3;
  logic [47:0]        sa4, sb4;
  norm_t              mag_p [2:4][3];
  norm_t              n_p   [2:DL];
  logic               neg_p [2:NS-2][3];
  logic               dflt_p [2:NS-1];
  speed_t             spd_p [DF:DL];
  rem_t               rem_p [DF:DL][3];
  dir_t               quo_p [DF:DL][3];
  logic signed [VEL_WIDTH-1:0] vel_p [0:NS-2][3];
  logic [54:0]        ph_b0 [3];
  logic [54:0]        pl_b0 [3];
  logic [48:0]        mag_b1 [3];
  logic signed [VEL_WIDTH-1:0] nv_b2 [3];

  // Stage 2 combinational sums
  logic signed [33:0] f2c [3];
  norm_t              n2c;
  always_comb begin
    n2c    = 33'(ww1) + 33'(xx1) + 33'(yy1) + 33'(zz1);
    f2c[0] = 34'(ww1) + 34'(xx1) - 34'(yy1) - 34'(zz1);
    f2c[1] = (34'(xy1) + 34'(wz1)) <<< 1;
    f2c[2] = (34'(xz1) - 34'(wy1)) <<< 1;
  end

  // Divider steps: stage j resolves quotient bits 2j and 2j+1 (the last stage only bit 30).
  rem_t rem_nx [DF+1:DL][3];
  dir_t quo_nx [DF+1:DL][3];
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    always_comb begin
      rem_t r;
      dir_t q;
      for (int l = 0; l < 3; l++) begin
        r = rem_p[DF+j][l];
        q = quo_p[DF+j][l];
        for (int t = 0; t < DIV_PER_STAGE; t++) begin
          if (DIV_PER_STAGE*j + t < DIV_STEPS) begin
            if (DIV_PER_STAGE*j + t > 0) r = {r[32:0], 1'b0};
            if (r >= {1'b0, n_p[DF+j]}) begin
              r = r - {1'b0, n_p[DF+j]};
              q = {q[29:0], 1'b1};
            end else begin
              q = {q[29:0], 1'b0};
            end
          end
        end
        rem_nx[DF+j+1][l] = r;
        quo_nx[DF+j+1][l] = q;
      end
    end
  end

  // Back stage 0: pick the direction, hold the default axis when n was zero.
  dir_t ad_b0 [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dflt_p[DL]) ad_b0[l] = (l == 0) ? DIR_ONE : '0;
      else            ad_b0[l] = quo_p[DL][l];
    end
  end

  // Back stage 1: full product sum, drop 30 fraction bits.
  logic [78:0] sum_b1 [3];
  always_comb begin
    for (int l = 0; l < 3; l++)
      sum_b1[l] = ({24'd0, ph_b0[l]} << 24) + {24'd0, pl_b0[l]};
  end

  // Back stage 2: signed add and saturate.
  logic signed [SW-1:0] sum_b2 [3];
  logic signed [49:0]   dl_b2 [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dl_b2[l]  = neg_p[NS-2][l] ? -$signed({1'b0, mag_b1[l]}) : $signed({1'b0, mag_b1[l]});
      sum_b2[l] = SW'(vel_p[NS-2][l]) + SW'(dl_b2[l]);
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers: advance on adv, no reset.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 0: reduce quaternion, clamp throttle
      q0[0] <= reduce_quat(quat_w);
      q0[1] <= reduce_quat(quat_x);
      q0[2] <= reduce_quat(quat_y);
      q0[3] <= reduce_quat(quat_z);
      if (throttle_level[31])                 thr0 <= '0;
      else if (throttle_level > 32'sd65536)   thr0 <= THR_ONE;
      else                                    thr0 <= throttle_level[16:0];
      im_p[0]     <= inverse_mass;
      vel_p[0][0] <= vel_x;
      vel_p[0][1] <= vel_y;
      vel_p[0][2] <= vel_z;
      // stage 1: products
      ww1 <= q0[0] * q0[0];
      xx1 <= q0[1] * q0[1];
      yy1 <= q0[2] * q0[2];
      zz1 <= q0[3] * q0[3];
      xy1 <= q0[1] * q0[2];
      wz1 <= q0[0] * q0[3];
      xz1 <= q0[1] * q0[3];
      wy1 <= q0[0] * q0[2];
      thrust1 <= 48'(thr0 * max_thrust);
      im_p[1] <= im_p[0];
      // stage 2: norm, direction numerators, acceleration partials
      n_p[2]    <= n2c;
      dflt_p[2] <= (n2c == '0);
      for (int l = 0; l < 3; l++) begin
        neg_p[2][l] <= f2c[l][33];
        mag_p[2][l] <= f2c[l][33] ? 33'(-f2c[l]) : f2c[l][32:0];
      end
      pa2     <= thrust1[31:0] * im_p[1];
      pb2     <= 48'(thrust1[47:32] * im_p[1]);
      // stages 3, 4: acceleration, speed partials
      accel3 <= pb2 + 48'(pa2[63:32]);
      sa4    <= accel3[47:24] * step_time;
      sb4    <= accel3[23:0] * step_time;
      mag_p[3] <= mag_p[2];
      mag_p[4] <= mag_p[3];
      // stage DF: speed, load the divider
      spd_p[DF] <= sa4 + 48'(sb4[47:24]);
      for (int l = 0; l < 3; l++) begin
        rem_p[DF][l] <= {1'b0, mag_p[4][l]};
        quo_p[DF][l] <= '0;
      end
      for (int k = DF+1; k <= DL; k++) begin
        rem_p[k] <= rem_nx[k];
        quo_p[k] <= quo_nx[k];
      end
      for (int k = 3; k <= DL; k++) n_p[k] <= n_p[k-1];
      for (int k = DF+1; k <= DL; k++) spd_p[k] <= spd_p[k-1];
      // back stage 0: scale partials
      for (int l = 0; l < 3; l++) begin
        ph_b0[l] <= spd_p[DL][47:24] * ad_b0[l];
        pl_b0[l] <= spd_p[DL][23:0] * ad_b0[l];
      end
      // back stage 1: magnitude
      for (int l = 0; l < 3; l++) mag_b1[l] <= sum_b1[l][78:30];
      // back stage 2: saturated result
      for (int l = 0; l < 3; l++) begin
        if (sum_b2[l] > VMAX)      nv_b2[l] <= VMAX[VEL_WIDTH-1:0];
        else if (sum_b2[l] < VMIN) nv_b2[l] <= VMIN[VEL_WIDTH-1:0];
        else                       nv_b2[l] <= sum_b2[l][VEL_WIDTH-1:0];
      end
      // side carries
      for (int k = 1; k <= NS-2; k++) vel_p[k]  <= vel_p[k-1];
      for (int k = 3; k <= NS-2; k++) neg_p[k]  <= neg_p[k-1];
      for (int k = 3; k <= NS-1; k++) dflt_p[k] <= dflt_p[k-1];
    end
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // Skid: hold the last word while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (out_ready) skid_vld <= 1'b0;
    end else if (vld[NS-1] && !out_ready) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld) begin
      skid_vel  <= nv_b2;
      skid_dflt <= dflt_p[NS-1];
    end
  end

  assign out_valid         = skid_vld || vld[NS-1];
  assign new_vel_x         = skid_vld ? skid_vel[0] : nv_b2[0];
  assign new_vel_y         = skid_vld ? skid_vel[1] : nv_b2[1];
  assign new_vel_z         = skid_vld ? skid_vel[2] : nv_b2[2];
  assign default_direction = skid_vld ? skid_dflt : dflt_p[NS-1];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `QTVU_ASSERT_NOW(a_stall_has_word, !in_ready, out_valid)
  `QTVU_ASSERT_NOW(a_div_rem_below_den, vld[DL] && !dflt_p[DL],
                   rem_p[DL][0] < {1'b0, n_p[DL]})
  `QTVU_ASSERT_NOW(a_default_axis_only_x, vld[NS-2] && dflt_p[NS-2],
                   mag_b1[1] == '0 && mag_b1[2] == '0)
  `QTVU_ASSERT_NEXT(a_skid_drains, skid_vld && out_ready, !skid_vld)

endmodule

// ===== sim/quaternion_thrust_velocity_update_unit_test.sv =====
// Self-checking bench for the thrust velocity update unit: random and directed ships,
// predicted velocities compared word by word. Depends on qtvu_pkg and the unit's RTL.
module quaternion_thrust_velocity_update_unit_test;
  import qtvu_pkg::*;

  localparam int QW = 16;
  localparam int VW = 48;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [QW-1:0] qw, qx, qy, qz;
    logic signed [31:0]   throttle;
    logic [31:0]          inv_mass;
    logic signed [VW-1:0] vx, vy, vz;
  } ship_t;

  typedef struct packed {
    logic signed [VW-1:0] vx, vy, vz;
    logic                 dflt;
  } velocity_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  ship_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VW-1:0] new_vel_x, new_vel_y, new_vel_z;
  logic default_direction;

  ship_t ship_queue[$];
  velocity_t expected_velocities[$];
  logic [31:0] thrust_reg;
  logic [23:0] step_reg;
  int failures = 0;
  int idle_cycles = 0;
  int gap_in = 0, gap_out = 0;
  bit no_idle = 1'b0;

  quaternion_thrust_velocity_update_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_w(cur.qw), .quat_x(cur.qx), .quat_y(cur.qy), .quat_z(cur.qz),
    .throttle_level(cur.throttle), .inverse_mass(cur.inv_mass),
    .vel_x(cur.vx), .vel_y(cur.vy), .vel_z(cur.vz),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z),
    .default_direction(default_direction)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Velocity component plus signed change, clamped to the signed VW range.
  function automatic logic signed [VW-1:0] sat_add(logic signed [VW-1:0] v,
                                                   logic signed [127:0] delta);
    logic signed [127:0] sum;
    logic signed [127:0] vmax;
    logic signed [127:0] vmin;
    sum = 128'(v) + delta;
    vmax = (128'sd1 <<< (VW - 1)) - 1;
    vmin = -vmax - 1;
    if (sum > vmax) return vmax[VW-1:0];
    if (sum < vmin) return vmin[VW-1:0];
    return sum[VW-1:0];
  endfunction

  // Thrust along the rotated forward axis; only ratios of the quaternion matter.
  function automatic velocity_t predict_velocity(ship_t s);
    velocity_t r;
    logic signed [127:0] w, x, y, z, n, f[3], d[3], ad, mag, thr;
    logic [127:0] thrust, accel, speed;
    w = 128'(s.qw); x = 128'(s.qx); y = 128'(s.qy); z = 128'(s.qz);
    n = w*w + x*x + y*y + z*z;
    r.dflt = (n == 0);
    if (r.dflt) begin
      d[0] = 128'sd1 <<< 30; d[1] = '0; d[2] = '0;
    end else begin
      f[0] = w*w + x*x - y*y - z*z;
      f[1] = 2 * (x*y + w*z);
      f[2] = 2 * (x*z - w*y);
      // SV division truncates toward zero, as wanted
      for (int i = 0; i < 3; i++) d[i] = (f[i] <<< 30) / n;
    end
    thr = 128'(s.throttle);
    if (thr < 0) thr = '0;
    if (thr > 65536) thr = 128'sd65536;
    thrust = thr * thrust_reg;
    accel = (thrust * s.inv_mass) >> 32;
    speed = (accel * step_reg) >> 24;
    for (int i = 0; i < 3; i++) begin
      ad = d[i] < 0 ? -d[i] : d[i];
      mag = (speed * ad) >> 30;
      d[i] = d[i] < 0 ? -mag : mag;
    end
    r.vx = sat_add(s.vx, d[0]);
    r.vy = sat_add(s.vy, d[1]);
    r.vz = sat_add(s.vz, d[2]);
    return r;
  endfunction

  // Driver: hold the word until taken, then advance after a random gap.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_velocities.push_back(predict_velocity(cur));
        gap_in <= pick_gap();
      end
      if (!in_valid || in_ready) begin
        if ((in_valid && in_ready ? pick_gap() : gap_in) == 0 && ship_queue.size() > 0) begin
          cur <= ship_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (!(in_valid && in_ready) && gap_in > 0) gap_in <= gap_in - 1;
        end
      end
    end
  end

  // Monitor: compare each taken word with the oldest prediction, stall at random.
  always @(posedge clk) begin
    velocity_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_velocities.size() == 0) begin
          $error("unexpected output word");
          failures++;
        end else begin
          e = expected_velocities.pop_front();
          if (new_vel_x !== e.vx) begin
            $error("new_vel_x expected %0d actual %0d", e.vx, new_vel_x); failures++;
          end
          if (new_vel_y !== e.vy) begin
            $error("new_vel_y expected %0d actual %0d", e.vy, new_vel_y); failures++;
          end
          if (new_vel_z !== e.vz) begin
            $error("new_vel_z expected %0d actual %0d", e.vz, new_vel_z); failures++;
          end
          if (default_direction !== e.dflt) begin
            $error("default_direction expected %0d actual %0d", e.dflt, default_direction);
            failures++;
          end
        end
      end
      if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        gap_out <= pick_gap();
      end
    end
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(int index, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * index); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (index == REG_MAX_THRUST) thrust_reg = value;
    else step_reg = value[23:0];
  endtask

  task automatic wait_drained();
    while (ship_queue.size() > 0 || in_valid || expected_velocities.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  // Random ship; unit-ish quaternions dominate, extremes sprinkled in.
  function automatic ship_t random_ship();
    ship_t s;
    int r;
    r = $urandom_range(0, 9);
    s.qw = QW'($urandom()); s.qx = QW'($urandom());
    s.qy = QW'($urandom()); s.qz = QW'($urandom());
    if (r < 5) begin
      s.qw = $signed(16'($urandom_range(0, 32767))) >>> 1;
      s.qx = $signed(16'($urandom())) >>> 2;
      s.qy = $signed(16'($urandom())) >>> 3;
      s.qz = $signed(16'($urandom())) >>> 3;
    end else if (r == 5) begin
      s.qw = '0; s.qx = '0; s.qy = '0; s.qz = '0;
    end
    r = $urandom_range(0, 9);
    s.throttle = r < 6 ? 32'($urandom_range(0, 65536)) : $urandom();
    s.inv_mass = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom();
    s.vx = rand48(); s.vy = rand48(); s.vz = rand48();
    if ($urandom_range(0, 7) == 0) s.vx = {1'b0, {(VW-1){1'b1}}} - 48'($urandom_range(0, 9));
    if ($urandom_range(0, 7) == 0) s.vy = {1'b1, {(VW-1){1'b0}}} + 48'($urandom_range(0, 9));
    return s;
  endfunction

  initial begin
    ship_t s;
    logic [31:0] thrusts[4];
    logic [31:0] steps[4];
    thrust_reg = MAX_THRUST_RESET;
    step_reg = STEP_TIME_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values first, then full thrust with extreme fields.
    for (int i = 0; i < 2; i++) ship_queue.push_back(random_ship());
    wait_drained();
    write_reg(REG_MAX_THRUST, 32'hFFFF_FFFF);
    write_reg(REG_STEP_TIME, 32'h00FF_FFFF);
    s = '0; s.throttle = 32'sh0001_0000; s.inv_mass = 32'hFFFF_FFFF;
    ship_queue.push_back(s);                            // zero quaternion
    s.qw = 16'sh4000; ship_queue.push_back(s);          // identity
    s.qw = 16'sh7FFF; s.qx = 16'sh7FFF; s.qy = 16'sh7FFF; s.qz = 16'sh7FFF;
    ship_queue.push_back(s);
    s.qw = 16'sh8000; s.qx = 16'sh8000; s.qy = 16'sh8000; s.qz = 16'sh8000;
    ship_queue.push_back(s);
    s.qw = '0; s.qx = '0; s.qy = 16'sh8000; s.qz = '0;  // forward flipped
    ship_queue.push_back(s);
    s.qw = 16'sh0001; s.qy = '0; ship_queue.push_back(s); // non-unit, tiny
    s.qw = 16'sh4000; s.qz = 16'sh4000; ship_queue.push_back(s);
    s.throttle = 32'sh8000_0000; ship_queue.push_back(s); // negative throttle
    s.throttle = 32'sh7FFF_FFFF; ship_queue.push_back(s); // above one
    s.throttle = 32'sh0000_FFFF; ship_queue.push_back(s);
    s.qw = 16'sh4000; s.qz = '0; s.throttle = 32'sh0001_0000;
    s.vx = {1'b0, {(VW-1){1'b1}}}; ship_queue.push_back(s); // overflow high
    s.qw = '0; s.qy = 16'sh4000; s.vx = {1'b1, {(VW-1){1'b0}}};
    ship_queue.push_back(s);                                 // overflow low
    s.vx = '1; s.vy = '1; s.vz = '1; s.inv_mass = '0; ship_queue.push_back(s);
    no_idle = 1'b1;
    for (int i = 0; i < 8; i++) ship_queue.push_back(random_ship());
    wait_drained();
    no_idle = 1'b0;

    // Random phases across several register settings.
    thrusts = '{32'd0, 32'hFFFF_FFFF, 32'd1000000, 32'd0};
    steps = '{32'd0, 32'h00FF_FFFF, 32'd279620, 32'd1};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_MAX_THRUST, p < 4 ? thrusts[p] : $urandom());
      write_reg(REG_STEP_TIME, p < 4 ? steps[p] : 32'($urandom_range(0, 16777215)));
      no_idle = (p == 2);
      for (int i = 0; i < 310; i++) ship_queue.push_back(random_ship());
      wait_drained();
    end

    if (failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
